/* rtl/assert_macros.svh */
// shared assertion macros for the page replacement checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define CHK_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrup check failed");

// next-cycle implication, disabled while reset is held
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrup check failed");

`endif

/* rtl/lrup_pkg.sv */
package lrup_pkg;

  // fixed field widths of the channels
  localparam int PAGE_W  = 16;
  localparam int SLOT_W  = 2;
  localparam int FAULT_W = 32;

  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // per-cell update control
  typedef struct packed {
    logic shift;  // take the upper neighbor's entry
    logic load;   // take the lifted or new entry
  } cell_ctl_t;

endpackage

/* rtl/lrup_if.sv */
interface lrup_in_if;
  logic                        valid;
  logic                        ready;
  logic [lrup_pkg::PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

interface lrup_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [lrup_pkg::SLOT_W-1:0]  frame_slot;
  logic                         evicted_valid;
  logic [lrup_pkg::PAGE_W-1:0]  evicted_page;
  logic [lrup_pkg::FAULT_W-1:0] faults_so_far;

  modport source (output valid, output hit, output frame_slot, output evicted_valid,
                  output evicted_page, output faults_so_far, input ready);
  modport sink (input valid, input hit, input frame_slot, input evicted_valid,
                input evicted_page, input faults_so_far, output ready);
endinterface

/* rtl/lrup_cell.sv */
module lrup_cell #(
  parameter int IDX_W     = 2,
  parameter int PAGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  valid,
  input  lrup_pkg::cell_ctl_t   ctl,
  input  logic [IDX_W-1:0]      up_idx,
  input  logic [PAGE_BITS-1:0]  up_page,
  input  logic [IDX_W-1:0]      load_idx,
  input  logic [PAGE_BITS-1:0]  load_page,
  input  logic [PAGE_BITS-1:0]  cmp_page,
  input  logic                  seen_in,
  output logic                  match,
  output logic                  seen_out,
  output logic [IDX_W-1:0]      idx,
  output logic [PAGE_BITS-1:0]  page
);

  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     idx_nxt;
  logic [PAGE_BITS-1:0] page_r;
  logic [PAGE_BITS-1:0] page_nxt;

  assign match    = valid && (page_r == cmp_page);
  // hit seen at this position or any lower one
  assign seen_out = seen_in | match;
  assign idx      = idx_r;
  assign page     = page_r;

  always_comb begin
    idx_nxt  = idx_r;
    page_nxt = page_r;
    if (ctl.load) begin
      idx_nxt  = load_idx;
      page_nxt = load_page;
    end else if (ctl.shift) begin
      idx_nxt  = up_idx;
      page_nxt = up_page;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    page_r <= page_nxt;
  end

endmodule

/* rtl/lru_page_replacement.sv */
// channel | dir | payload                                               | beat when
// in_ch   | in  | page_number                                           | valid && ready
// out_ch  | out | hit, frame_slot, evicted_valid, evicted_page, faults  | valid && ready
//
// one reference per cycle unless a held result stalls input: the match across all cells
// and the one-step shift of the recency chain both finish in the accepting cycle;
// result is registered and shows in the cycle after the input beat.
// rst_n (synchronous) empties the frames and clears the fault count.
// an unaccepted result stalls input; accepting the result frees the register at once.
module lru_page_replacement #(
  parameter int NUM_FRAMES = 4,
  parameter int PAGE_BITS  = 16
) (
  input logic      clk,
  input logic      rst_n,
  lrup_in_if.sink  in_ch,
  lrup_out_if.source out_ch
);

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);

  logic [CNT_W-1:0]                filled_r;
  logic [CNT_W-1:0]                filled_nxt;
  logic [lrup_pkg::FAULT_W-1:0]    fault_r;
  logic [lrup_pkg::FAULT_W-1:0]    fault_nxt;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic                            hit_r;
  logic [lrup_pkg::SLOT_W-1:0]     slot_r;
  logic                            ev_valid_r;
  logic [lrup_pkg::PAGE_W-1:0]     ev_page_r;

  logic                            go;
  logic                            any_hit;
  logic                            full;
  logic                            lift;
  logic [PAGE_BITS-1:0]            req_page;
  logic [IDX_W-1:0]                hit_idx;
  logic [IDX_W-1:0]                new_idx;

  logic [NUM_FRAMES-1:0]           valid;
  logic [NUM_FRAMES-1:0]           match;
  logic [NUM_FRAMES:0]             seen;
  logic [IDX_W-1:0]                cell_idx  [NUM_FRAMES];
  logic [PAGE_BITS-1:0]            cell_page [NUM_FRAMES];
  lrup_pkg::cell_ctl_t             ctl       [NUM_FRAMES];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign go          = in_ch.valid && in_ch.ready;
  assign req_page    = PAGE_BITS'(in_ch.page_number);
  assign full        = (filled_r == CNT_W'(NUM_FRAMES));
  assign any_hit     = seen[NUM_FRAMES];
  // hit or full miss moves an entry to the top of the chain
  assign lift        = any_hit || full;
  assign seen[0]     = 1'b0;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (match[i]) hit_idx = hit_idx | cell_idx[i];
    end
  end

  always_comb begin
    if (any_hit) new_idx = hit_idx;
    else if (full) new_idx = cell_idx[0];
    else new_idx = filled_r[IDX_W-1:0];
  end

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    logic [IDX_W-1:0]     up_idx;
    logic [PAGE_BITS-1:0] up_page;

    assign valid[g] = CNT_W'(g) < filled_r;

    if (g == NUM_FRAMES - 1) begin : g_top
      assign up_idx  = new_idx;
      assign up_page = req_page;
    end else begin : g_mid
      assign up_idx  = cell_idx[g+1];
      assign up_page = cell_page[g+1];
    end

    // on a hit only the entries from the hit position up shift down
    always_comb begin
      ctl[g].shift = go && lift && (!any_hit || seen[g+1]) && (CNT_W'(g + 1) < filled_r);
      ctl[g].load  = go && ((lift && (CNT_W'(g + 1) == filled_r)) ||
                            (!lift && (CNT_W'(g) == filled_r)));
    end

    lrup_cell #(
      .IDX_W    (IDX_W),
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk      (clk),
      .valid    (valid[g]),
      .ctl      (ctl[g]),
      .up_idx   (up_idx),
      .up_page  (up_page),
      .load_idx (new_idx),
      .load_page(req_page),
      .cmp_page (req_page),
      .seen_in  (seen[g]),
      .match    (match[g]),
      .seen_out (seen[g+1]),
      .idx      (cell_idx[g]),
      .page     (cell_page[g])
    );
  end

  always_comb begin
    filled_nxt    = filled_r;
    fault_nxt     = fault_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (go) begin
      out_valid_nxt = 1'b1;
      if (!any_hit) begin
        if (fault_r != lrup_pkg::FAULT_MAX) fault_nxt = fault_r + 1'b1;
        if (!full) filled_nxt = filled_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      filled_r    <= filled_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hit_r      <= any_hit;
      slot_r     <= lrup_pkg::SLOT_W'(new_idx);
      ev_valid_r <= !any_hit && full;
      ev_page_r  <= (!any_hit && full) ? lrup_pkg::PAGE_W'(cell_page[0]) : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = hit_r;
  assign out_ch.frame_slot    = slot_r;
  assign out_ch.evicted_valid = ev_valid_r;
  assign out_ch.evicted_page  = ev_page_r;
  assign out_ch.faults_so_far = fault_r;

endmodule

/* rtl/lrup_checker.sv */
`include "assert_macros.svh"

module lrup_checker #(
  parameter int NUM_FRAMES = 4
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_hit,
  input logic [lrup_pkg::SLOT_W-1:0]  out_frame_slot,
  input logic                         out_evicted_valid,
  input logic [lrup_pkg::PAGE_W-1:0]  out_evicted_page,
  input logic [lrup_pkg::FAULT_W-1:0] out_faults_so_far
);

  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
            out_valid && $stable(out_frame_slot) && $stable(out_faults_so_far))

  `CHK_SAME(a_stall_backpressure, clk, rst_n, out_valid && !out_ready, !in_ready)

  `CHK_SAME(a_hit_no_evict, clk, rst_n, out_valid && out_hit, !out_evicted_valid)

  `CHK_SAME(a_no_evict_zero, clk, rst_n, out_valid && !out_evicted_valid,
            out_evicted_page == '0)

  `CHK_SAME(a_evict_after_fill, clk, rst_n, out_valid && out_evicted_valid,
            out_faults_so_far > lrup_pkg::FAULT_W'(NUM_FRAMES))

endmodule

bind lru_page_replacement lrup_checker #(
  .NUM_FRAMES(NUM_FRAMES)
) u_lrup_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_hit          (out_ch.hit),
  .out_frame_slot   (out_ch.frame_slot),
  .out_evicted_valid(out_ch.evicted_valid),
  .out_evicted_page (out_ch.evicted_page),
  .out_faults_so_far(out_ch.faults_so_far)
);

/* verif/tb_lru_page_replacement.sv */
`timescale 1ns / 100ps

module tb_lru_page_replacement;

  localparam int FRAMES     = 4;
  localparam int IDLE_PCT   = 12;
  localparam int HOLD_LEN   = 60;
  localparam int STALL_MAX  = 1000;
  localparam int CHUNKS     = 5;
  localparam int CHUNK_REFS = 200;
  localparam int WSET       = 6;

  typedef struct packed {
    logic                         hit;
    logic [lrup_pkg::SLOT_W-1:0]  slot;
    logic                         ev_valid;
    logic [lrup_pkg::PAGE_W-1:0]  ev_page;
    logic [lrup_pkg::FAULT_W-1:0] faults;
  } lookup_t;

  logic clk;
  logic rst_n;

  lrup_in_if  in_ch ();
  lrup_out_if out_ch ();

  lru_page_replacement #(
    .NUM_FRAMES(FRAMES),
    .PAGE_BITS (lrup_pkg::PAGE_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the frame table and recency order
  logic [lrup_pkg::PAGE_W-1:0]  res_pages [FRAMES];
  logic [lrup_pkg::SLOT_W-1:0]  lru_order [FRAMES];
  int                           res_filled;
  logic [lrup_pkg::FAULT_W-1:0] fault_cnt;

  logic [lrup_pkg::PAGE_W-1:0] page_refs [$];
  lookup_t                     predicted [$];

  int   refs_issued;
  int   results_seen;
  int   mismatches;
  int   stall_cycles;
  logic in_took;
  logic calm;
  int   hold_asks;
  int   hold_seen;
  int   hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // move the order entry at pos to the most-recent end
  function automatic void promote(input int pos);
    logic [lrup_pkg::SLOT_W-1:0] held;
    int                          k;
    held = lru_order[pos];
    for (k = pos; k < res_filled - 1; k++) lru_order[k] = lru_order[k + 1];
    lru_order[res_filled - 1] = held;
  endfunction

  function automatic lookup_t reference_page(input logic [lrup_pkg::PAGE_W-1:0] page);
    lookup_t r;
    int      k;
    int      pos;
    r   = '0;
    pos = 0;
    for (k = 0; k < res_filled; k++) begin
      if (!r.hit && res_pages[k] == page) begin
        r.hit  = 1'b1;
        r.slot = lrup_pkg::SLOT_W'(k);
      end
    end
    if (r.hit) begin
      for (k = res_filled - 1; k >= 0; k--) if (lru_order[k] == r.slot) pos = k;
      promote(pos);
    end else begin
      if (fault_cnt != lrup_pkg::FAULT_MAX) fault_cnt = fault_cnt + 1;
      if (res_filled < FRAMES) begin
        r.slot                = lrup_pkg::SLOT_W'(res_filled);
        lru_order[res_filled] = r.slot;
        res_pages[res_filled] = page;
        res_filled++;
      end else begin
        r.slot             = lru_order[0];
        r.ev_valid         = 1'b1;
        r.ev_page          = res_pages[r.slot];
        res_pages[r.slot]  = page;
        promote(0);
      end
    end
    r.faults = fault_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_ref(input logic [lrup_pkg::PAGE_W-1:0] page);
    page_refs.push_back(page);
    refs_issued++;
  endtask

  task automatic wait_drained();
    while (results_seen != refs_issued) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_took) begin
        if (page_refs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.valid       <= 1'b1;
          in_ch.page_number <= page_refs.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_asks != hold_seen) begin
        hold_seen    <= hold_asks;
        hold_left    <= HOLD_LEN;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // monitor: record input beats, check result beats
  always @(posedge clk) begin : monitor
    lookup_t want;
    logic    in_beat;
    logic    out_beat;
    in_beat  = rst_n && in_ch.valid && in_ch.ready;
    out_beat = rst_n && out_ch.valid && out_ch.ready;
    in_took <= in_beat;
    if (out_beat) begin
      results_seen <= results_seen + 1;
      if (predicted.size() == 0) begin
        $display("%0t: unexpected result beat, hit %0b slot %0d", $time, out_ch.hit,
                 out_ch.frame_slot);
        mismatches++;
      end else begin
        want = predicted.pop_front();
        check_field("hit", 32'(want.hit), 32'(out_ch.hit));
        check_field("frame_slot", 32'(want.slot), 32'(out_ch.frame_slot));
        check_field("evicted_valid", 32'(want.ev_valid), 32'(out_ch.evicted_valid));
        check_field("evicted_page", 32'(want.ev_page), 32'(out_ch.evicted_page));
        check_field("faults_so_far", want.faults, out_ch.faults_so_far);
      end
    end
    if (in_beat) predicted.push_back(reference_page(in_ch.page_number));
    if (in_beat || out_beat || results_seen == refs_issued) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_MAX) begin
      $display("lru_page_replacement: mismatch");
      $finish;
    end
  end

  initial begin
    logic [lrup_pkg::PAGE_W-1:0] wset [WSET];
    int                          c;
    int                          n;
    int                          k;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.page_number = '0;
    out_ch.ready      = 1'b0;
    in_took           = 1'b0;
    calm              = 1'b0;
    hold_asks         = 0;
    hold_seen         = 0;
    hold_left         = 0;
    refs_issued       = 0;
    results_seen      = 0;
    mismatches        = 0;
    stall_cycles      = 0;
    res_filled        = 0;
    fault_cnt         = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill, hits on bottom/middle/top of the order, repeats, evictions
    add_ref(16'h0000);
    add_ref(16'h0000);
    add_ref(16'hFFFF);
    add_ref(16'h0000);
    add_ref(16'h1234);
    add_ref(16'hA5A5);
    add_ref(16'h5A5A);
    add_ref(16'h1234);
    add_ref(16'h5A5A);
    add_ref(16'h0000);
    add_ref(16'hFFFF);
    add_ref(16'h8000);
    add_ref(16'h0001);
    add_ref(16'hA5A5);
    add_ref(16'h8000);
    add_ref(16'h7FFF);
    add_ref(16'h0001);
    add_ref(16'hFFFF);
    wait_drained();

    for (c = 0; c < CHUNKS; c++) begin
      calm = (c == 2);
      if (c == 3) hold_asks++;
      for (k = 0; k < WSET; k++) wset[k] = lrup_pkg::PAGE_W'($urandom_range(16'hFFFF));
      for (n = 0; n < CHUNK_REFS; n++) begin
        // let the working set drift so evicted pages come back later
        if (n % 40 == 39) begin
          wset[$urandom_range(WSET - 1)] = lrup_pkg::PAGE_W'($urandom_range(16'hFFFF));
        end
        if ($urandom_range(99) < 85) begin
          add_ref(wset[$urandom_range(WSET - 1)]);
        end else begin
          add_ref(lrup_pkg::PAGE_W'($urandom_range(16'hFFFF)));
        end
      end
      // sender holds back until the block has drained
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("lru_page_replacement: match");
    end else begin
      $display("lru_page_replacement: mismatch");
    end
    $finish;
  end

endmodule
